>>> rtl/tga_rle_decoder_assert.svh
// Assertion macros for the TGA run-length decoder.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef TGA_RLE_DECODER_ASSERT_SVH
`define TGA_RLE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tga_pkg.sv
// Shared types and constants of the TGA run-length decoder.
// No dependencies; imported by every module of the block.
package tga_pkg;

  localparam int TdataW = 112;

  // Result kinds, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_IDSKIP = 5'b00100,
    PH_PKTHDR = 5'b01000,
    PH_PIXEL  = 5'b10000
  } phase_e;

  // Header byte positions.
  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  // Supported image types.
  localparam logic [7:0] TYPE_RAW_COLOR = 8'd2;
  localparam logic [7:0] TYPE_RAW_GRAY  = 8'd3;
  localparam logic [7:0] TYPE_RLE_COLOR = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY  = 8'd11;

  localparam logic [7:0] BITS_8  = 8'd8;
  localparam logic [7:0] BITS_24 = 8'd24;
  localparam logic [7:0] BITS_32 = 8'd32;

  // Internal pixel depth codes.
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_24 = 2'd1;
  localparam logic [1:0] DEPTH_32 = 2'd2;

  localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;
  localparam int         PKT_RUN_BIT    = 7;
  localparam int         DESC_FLIP_BIT  = 5;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] start_index;
    logic [7:0]  run_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        flip_vertical;
    logic        last;
    logic        alpha_empty;
  } result_t;

endpackage

>>> rtl/tga_in_stage.sv
// Input register of the TGA decoder: holds one byte word until the core takes it.
// Depends on tga_pkg.
module tga_in_stage
  import tga_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_word_t s_word_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  // Room exists when empty or when the held word leaves this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign valid_d   = (s_valid_i && s_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      word_q <= s_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> rtl/tga_core.sv
// Parser core of the TGA decoder: header, id skip, packet and pixel state.
// Depends on tga_pkg; produces at most one result per stepped byte.
module tga_core
  import tga_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_word_t word_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  phase_e      phase_q, phase_d, phase_cur;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_cur;
  logic [7:0]  id_left_q, id_left_d;
  logic        compressed_q, compressed_d;
  logic [1:0]  depth_q, depth_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        flip_q, flip_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] pix_idx_q, pix_idx_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [23:0] colour_q, colour_d;
  logic        alpha_seen_q, alpha_seen_d;
  logic [7:0]  cmap_q, cmap_d;
  logic [7:0]  itype_q, itype_d;
  logic [7:0]  bits_q, bits_d;

  logic [7:0]  d;
  logic [31:0] area;
  logic        is_colour, is_gray, hdr_ok, img_empty;
  logic [2:0]  bpp;
  logic        pix_done;
  logic        clip;
  logic [7:0]  run_len;
  logic [7:0]  len;
  logic        pix_last;
  logic [7:0]  alpha_val;

  assign d           = word_i.data_byte;
  assign phase_cur   = word_i.first ? PH_HEADER : phase_q;
  assign hdr_cnt_cur = word_i.first ? HDR_ID_LEN : hdr_cnt_q;

  // Width and height are settled well before the descriptor byte.
  assign area      = {16'b0, width_q} * {16'b0, height_q};
  assign img_empty = (width_q == '0) || (height_q == '0);

  assign is_colour = itype_q inside {TYPE_RAW_COLOR, TYPE_RLE_COLOR};
  assign is_gray   = itype_q inside {TYPE_RAW_GRAY, TYPE_RLE_GRAY};
  assign hdr_ok    = (is_colour || is_gray) && (cmap_q == '0)
                   && !(is_colour && (bits_q != BITS_24) && (bits_q != BITS_32))
                   && !(is_gray && (bits_q != BITS_8));

  assign bpp      = (depth_q == DEPTH_8) ? 3'd1 : ((depth_q == DEPTH_24) ? 3'd3 : 3'd4);
  assign pix_done = ({1'b0, byte_pos_q} + 3'd1) >= bpp;

  // A run is cut to the pixels still missing from the image.
  assign clip     = (remain_q[31:8] == '0) && (remain_q[7:0] < pkt_left_q);
  assign run_len  = clip ? remain_q[7:0] : pkt_left_q;
  assign len      = (compressed_q && pkt_run_q) ? run_len : 8'd1;
  assign pix_last = ({24'b0, len} == remain_q);
  assign alpha_val = (bpp == 3'd4) ? d : ALPHA_OPAQUE;

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    id_left_d    = id_left_q;
    compressed_d = compressed_q;
    depth_d      = depth_q;
    width_d      = width_q;
    height_d     = height_q;
    flip_d       = flip_q;
    remain_d     = remain_q;
    pix_idx_d    = pix_idx_q;
    pkt_left_d   = pkt_left_q;
    pkt_run_d    = pkt_run_q;
    byte_pos_d   = byte_pos_q;
    colour_d     = colour_q;
    alpha_seen_d = alpha_seen_q;
    cmap_d       = cmap_q;
    itype_d      = itype_q;
    bits_d       = bits_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (step_i) begin
      if (word_i.first) begin
        phase_d   = PH_HEADER;
        hdr_cnt_d = HDR_ID_LEN;
        width_d   = '0;
        height_d  = '0;
        cmap_d    = '0;
        itype_d   = '0;
        bits_d    = '0;
      end

      case (phase_cur)
        PH_HEADER: begin
          hdr_cnt_d = hdr_cnt_cur + 5'd1;
          case (hdr_cnt_cur)
            HDR_ID_LEN:    id_left_d = d;
            HDR_CMAP_TYPE: cmap_d = d;
            HDR_IMG_TYPE:  itype_d = d;
            HDR_WIDTH_LO:  width_d = {width_q[15:8], d};
            HDR_WIDTH_HI:  width_d = {d, width_q[7:0]};
            HDR_HEIGHT_LO: height_d = {height_q[15:8], d};
            HDR_HEIGHT_HI: height_d = {d, height_q[7:0]};
            HDR_DEPTH:     bits_d = d;
            HDR_DESC: begin
              hdr_cnt_d   = hdr_cnt_cur;
              res_valid_o = 1'b1;
              if (!hdr_ok) begin
                phase_d    = PH_WAIT;
                res_o.kind = KIND_ERROR;
                res_o.last = 1'b1;
              end else begin
                compressed_d = (itype_q == TYPE_RLE_COLOR) || (itype_q == TYPE_RLE_GRAY);
                depth_d      = is_gray ? DEPTH_8 : ((bits_q == BITS_24) ? DEPTH_24 : DEPTH_32);
                flip_d       = d[DESC_FLIP_BIT];
                remain_d     = area;
                pix_idx_d    = '0;
                alpha_seen_d = 1'b0;
                colour_d     = '0;
                res_o.kind          = KIND_HEADER;
                res_o.image_width   = width_q;
                res_o.image_height  = height_q;
                res_o.flip_vertical = d[DESC_FLIP_BIT];
                if (img_empty) begin
                  phase_d           = PH_WAIT;
                  res_o.last        = 1'b1;
                  res_o.alpha_empty = 1'b1;
                end else if (id_left_q != '0) begin
                  phase_d = PH_IDSKIP;
                end else begin
                  byte_pos_d = '0;
                  pkt_left_d = '0;
                  pkt_run_d  = 1'b0;
                  phase_d    = compressed_d ? PH_PKTHDR : PH_PIXEL;
                end
              end
            end
            default: ;
          endcase
        end
        PH_IDSKIP: begin
          if (id_left_q != '0) begin
            id_left_d = id_left_q - 8'd1;
          end
          if (id_left_d == '0) begin
            byte_pos_d = '0;
            pkt_left_d = '0;
            pkt_run_d  = 1'b0;
            phase_d    = compressed_q ? PH_PKTHDR : PH_PIXEL;
          end
        end
        PH_PKTHDR: begin
          pkt_left_d = (d & PKT_COUNT_MASK) + 8'd1;
          pkt_run_d  = d[PKT_RUN_BIT];
          byte_pos_d = '0;
          phase_d    = PH_PIXEL;
        end
        PH_PIXEL: begin
          case (byte_pos_q)
            2'd0:    colour_d[7:0]   = d;
            2'd1:    colour_d[15:8]  = d;
            2'd2:    colour_d[23:16] = d;
            default: ;
          endcase
          if (pix_done) begin
            if ((bpp == 3'd4) && (d != '0)) begin
              alpha_seen_d = 1'b1;
            end
            pix_idx_d  = pix_idx_q + {24'b0, len};
            remain_d   = remain_q - {24'b0, len};
            byte_pos_d = '0;
            if (compressed_q) begin
              pkt_left_d = (pkt_run_q || (pkt_left_q <= 8'd1)) ? 8'd0 : pkt_left_q - 8'd1;
            end
            if (pix_last) begin
              phase_d = PH_WAIT;
            end else if (compressed_q && (pkt_left_d == '0)) begin
              phase_d = PH_PKTHDR;
            end else begin
              phase_d = PH_PIXEL;
            end
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_PIXEL;
            res_o.blue        = colour_d[7:0];
            res_o.green       = (depth_q == DEPTH_8) ? colour_d[7:0] : colour_d[15:8];
            res_o.red         = (depth_q == DEPTH_8) ? colour_d[7:0] : colour_d[23:16];
            res_o.alpha       = alpha_val;
            res_o.start_index = pix_idx_q;
            res_o.run_length  = len;
            res_o.last        = pix_last;
            res_o.alpha_empty = pix_last && !alpha_seen_d;
          end else begin
            byte_pos_d = byte_pos_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      hdr_cnt_q    <= '0;
      id_left_q    <= '0;
      compressed_q <= 1'b0;
      depth_q      <= DEPTH_8;
      width_q      <= '0;
      height_q     <= '0;
      flip_q       <= 1'b0;
      remain_q     <= '0;
      pix_idx_q    <= '0;
      pkt_left_q   <= '0;
      pkt_run_q    <= 1'b0;
      byte_pos_q   <= '0;
      colour_q     <= '0;
      alpha_seen_q <= 1'b0;
      cmap_q       <= '0;
      itype_q      <= '0;
      bits_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      hdr_cnt_q    <= hdr_cnt_d;
      id_left_q    <= id_left_d;
      compressed_q <= compressed_d;
      depth_q      <= depth_d;
      width_q      <= width_d;
      height_q     <= height_d;
      flip_q       <= flip_d;
      remain_q     <= remain_d;
      pix_idx_q    <= pix_idx_d;
      pkt_left_q   <= pkt_left_d;
      pkt_run_q    <= pkt_run_d;
      byte_pos_q   <= byte_pos_d;
      colour_q     <= colour_d;
      alpha_seen_q <= alpha_seen_d;
      cmap_q       <= cmap_d;
      itype_q      <= itype_d;
      bits_q       <= bits_d;
    end
  end

endmodule

>>> rtl/tga_out_stage.sv
// Result register of the TGA decoder: holds one result word for the consumer.
// Depends on tga_pkg.
module tga_out_stage
  import tga_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  input  logic    m_ready_i,
  output logic    m_valid_o,
  output result_t m_res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || m_ready_i;
  assign valid_d = load_i || (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

>>> rtl/tga_rle_decoder.sv
// TGA run-length image decoder, top level: input register, parser core, result register.
// Each byte waits in the input register, is parsed combinationally by the core and its
// result is registered in the result register. Throughput: one input byte per cycle while
// the result register has room, set by the single-pass core; only descriptor bytes and
// final pixel bytes give a result. Reset (rst_ni low, asynchronous) empties both registers
// and returns the parser to waiting for a byte flagged as the first of a file.
module tga_rle_decoder
  import tga_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream: one file byte per word.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tuser,   // [0] first
  // Output stream: one result per word.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [63:32] start_index,
  // [71:64] run_length, [87:72] image_width, [103:88] image_height,
  // [104] flip_vertical, [105] alpha_empty, [111:106] zero
  output logic [TdataW-1:0] m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [1:0] kind
  output logic              m_axis_tlast    // last
);

  in_word_t s_word;
  in_word_t core_word;
  logic     core_valid;
  logic     out_ready;
  logic     step;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign s_word.data_byte = s_axis_tdata;
  assign s_word.first     = s_axis_tuser;

  // The core advances whenever it holds a byte and the result register has room.
  // While a result waits in a full result register, every byte is held off until
  // the consumer takes that result.
  assign step = core_valid && out_ready;

  tga_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_word_i  (s_word),
    .take_i    (step),
    .valid_o   (core_valid),
    .word_o    (core_word)
  );

  tga_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (core_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tga_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && res_valid),
    .res_i     (res),
    .ready_o   (out_ready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_res_o   (out_res)
  );

  // Pack the result fields from the lowest bit up.
  assign m_axis_tdata = {6'b0, out_res.alpha_empty, out_res.flip_vertical,
                         out_res.image_height, out_res.image_width, out_res.run_length,
                         out_res.start_index, out_res.alpha, out_res.blue,
                         out_res.green, out_res.red};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

`include "tga_rle_decoder_assert.svh"

  // A byte held in the input register is never dropped while the core is stalled.
  `TGA_ASSERT_NEXT(a_held_byte_kept, core_valid && !step, core_valid, "held byte lost")
  // A format error always closes the file.
  `TGA_ASSERT_NOW(a_error_is_last,
                  m_axis_tvalid && (m_axis_tuser == KIND_ERROR),
                  m_axis_tlast, "error result not last")
  // Pixel results always cover at least one pixel.
  `TGA_ASSERT_NOW(a_run_nonzero,
                  m_axis_tvalid && (m_axis_tuser == KIND_PIXEL),
                  m_axis_tdata[71:64] != '0, "empty pixel run")
  // The empty-alpha flag is only reported on the final result.
  `TGA_ASSERT_NOW(a_alpha_flag_last, m_axis_tvalid && m_axis_tdata[105],
                  m_axis_tlast, "alpha flag before last")

endmodule

>>> dv/tb_tga_rle_decoder.sv
// Self-checking testbench for the TGA run-length decoder: streams whole and broken
// Targa files into tga_rle_decoder and checks every result word against a built-in decoder.
// Depends on tga_pkg and the RTL of tga_rle_decoder only.
module tb_tga_rle_decoder;
  import tga_pkg::*;

  localparam int ItemTarget  = 1150;  // input words after which the random files stop
  localparam int HoldCycles  = 200;   // length of the long receiver stall
  localparam int StallLimit  = 2000;  // cycles without any handshake before giving up
  localparam int DrainCycles = 8;     // wait after the last expected word, for strays

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;   // [7:0] data_byte
  logic              s_axis_tuser  = 1'b0; // [0] first
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [63:32] start_index,
  // [71:64] run_length, [87:72] image_width, [103:88] image_height,
  // [104] flip_vertical, [105] alpha_empty, [111:106] zero
  logic [TdataW-1:0] m_axis_tdata;
  logic [1:0]        m_axis_tuser;        // [1:0] kind
  logic              m_axis_tlast;        // last

  tga_rle_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shared run state. The burst flags switch off the random idling of one side, and
  // hold_output asks the output sink for one long stall.
  bit      send_burst  = 1'b0;
  bit      recv_burst  = 1'b0;
  bit      hold_output = 1'b0;
  int      bytes_sent  = 0;
  int      n_words     = 0;
  int      n_errors    = 0;
  int      idle_cycles = 0;
  result_t pending_results[$];

  // Decoder state as the block should hold it. It starts at its reset values, and the
  // block is reset only once, so it is never cleared again.
  phase_e      st_phase      = PH_WAIT;
  logic [4:0]  st_hcount     = '0;
  logic [7:0]  st_id_left    = '0;
  logic        st_rle        = 1'b0;
  logic [1:0]  st_depth      = DEPTH_8;
  logic [15:0] st_width      = '0;
  logic [15:0] st_height     = '0;
  logic        st_flip       = 1'b0;
  logic [31:0] st_total      = '0;
  logic [31:0] st_index      = '0;
  logic [7:0]  st_pkt_left   = '0;
  logic        st_pkt_run    = 1'b0;
  logic [1:0]  st_byte_k     = '0;
  logic [23:0] st_color      = '0;  // blue in [7:0], green in [15:8], red in [23:16]
  logic        st_alpha_seen = 1'b0;
  logic [7:0]  st_cmap       = '0;
  logic [7:0]  st_type       = '0;
  logic [7:0]  st_bits       = '0;

  // Pixel data begins: RLE files start with a packet header, raw files with a pixel.
  task automatic enter_data();
    st_byte_k   = '0;
    st_pkt_left = '0;
    st_pkt_run  = 1'b0;
    st_phase    = st_rle ? PH_PKTHDR : PH_PIXEL;
  endtask

  // Advances the decoder state by one accepted file byte and queues the result it causes.
  task automatic decode_byte(input logic [7:0] d, input logic f);
    result_t     res;
    bit          have;
    int unsigned k, bpp;
    logic [31:0] remain, len;
    logic        is_color, is_gray, ok;
    res  = '0;
    have = 1'b0;
    // A byte flagged as first always restarts the header parse, even mid-image.
    if (f) begin
      st_phase  = PH_HEADER;
      st_hcount = '0;
      st_width  = '0;
      st_height = '0;
      st_cmap   = '0;
      st_type   = '0;
      st_bits   = '0;
    end
    case (st_phase)
      PH_HEADER: begin
        case (st_hcount)
          HDR_ID_LEN:    st_id_left = d;
          HDR_CMAP_TYPE: st_cmap = d;
          HDR_IMG_TYPE:  st_type = d;
          HDR_WIDTH_LO:  st_width[7:0] = d;
          HDR_WIDTH_HI:  st_width[15:8] = d;
          HDR_HEIGHT_LO: st_height[7:0] = d;
          HDR_HEIGHT_HI: st_height[15:8] = d;
          HDR_DEPTH:     st_bits = d;
          default: ;
        endcase
        if (st_hcount != HDR_DESC) begin
          st_hcount = st_hcount + 5'd1;
        end else begin
          // The descriptor byte closes the header and the format is judged here.
          is_color = (st_type == TYPE_RAW_COLOR) || (st_type == TYPE_RLE_COLOR);
          is_gray  = (st_type == TYPE_RAW_GRAY) || (st_type == TYPE_RLE_GRAY);
          ok       = (is_color || is_gray) && (st_cmap == 8'd0);
          if (is_color && st_bits != BITS_24 && st_bits != BITS_32) ok = 1'b0;
          if (is_gray && st_bits != BITS_8) ok = 1'b0;
          have = 1'b1;
          if (!ok) begin
            st_phase = PH_WAIT;
            res.kind = KIND_ERROR;
            res.last = 1'b1;
          end else begin
            st_rle        = (st_type >= TYPE_RLE_COLOR);
            st_depth      = is_gray ? DEPTH_8 : ((st_bits == BITS_24) ? DEPTH_24 : DEPTH_32);
            st_flip       = d[DESC_FLIP_BIT];
            st_total      = {16'd0, st_width} * {16'd0, st_height};
            st_index      = '0;
            st_alpha_seen = 1'b0;
            st_color      = '0;
            res.kind          = KIND_HEADER;
            res.image_width   = st_width;
            res.image_height  = st_height;
            res.flip_vertical = st_flip;
            if (st_total == 0) begin
              // An image with no pixels ends on its header word.
              st_phase        = PH_WAIT;
              res.last        = 1'b1;
              res.alpha_empty = 1'b1;
            end else if (st_id_left != 0) begin
              st_phase = PH_IDSKIP;
            end else begin
              enter_data();
            end
          end
        end
      end
      PH_IDSKIP: begin
        if (st_id_left != 0) st_id_left = st_id_left - 8'd1;
        if (st_id_left == 0) enter_data();
      end
      PH_PKTHDR: begin
        st_pkt_left = (d & PKT_COUNT_MASK) + 8'd1;
        st_pkt_run  = d[PKT_RUN_BIT];
        st_byte_k   = '0;
        st_phase    = PH_PIXEL;
      end
      PH_PIXEL: begin
        bpp = (st_depth == DEPTH_8) ? 1 : ((st_depth == DEPTH_24) ? 3 : 4);
        k   = st_byte_k;
        if (k < 3) st_color[8*k +: 8] = d;
        if (k + 1 >= bpp) begin
          have      = 1'b1;
          res.kind  = KIND_PIXEL;
          res.blue  = st_color[7:0];
          res.green = (st_depth == DEPTH_8) ? st_color[7:0] : st_color[15:8];
          res.red   = (st_depth == DEPTH_8) ? st_color[7:0] : st_color[23:16];
          res.alpha = (bpp == 4) ? d : ALPHA_OPAQUE;
          if (bpp == 4 && d != 8'd0) st_alpha_seen = 1'b1;
          // A run is cut to the pixels that remain in the image.
          remain = st_total - st_index;
          len    = 32'd1;
          if (st_rle && st_pkt_run) begin
            len = ({24'd0, st_pkt_left} > remain) ? remain : {24'd0, st_pkt_left};
          end
          res.start_index = st_index;
          res.run_length  = len[7:0];
          st_index        = st_index + len;
          res.last        = (st_index >= st_total);
          res.alpha_empty = res.last & ~st_alpha_seen;
          if (st_rle) begin
            st_pkt_left = (st_pkt_run || st_pkt_left <= 8'd1) ? 8'd0 : st_pkt_left - 8'd1;
          end
          st_byte_k = '0;
          if (res.last) st_phase = PH_WAIT;
          else if (st_rle && st_pkt_left == 8'd0) st_phase = PH_PKTHDR;
          else st_phase = PH_PIXEL;
        end else begin
          st_byte_k = 2'(k + 1);
        end
      end
      default: ;
    endcase
    if (have) pending_results.push_back(res);
  endtask

  // Offers one file byte after a random pause (none in a burst) and returns once it has been taken.
  task automatic send_byte(input logic [7:0] d, input logic f);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_byte(d, f);
    bytes_sent++;
  endtask

  // Sends the 18 header bytes, random where the block does not look, then the id field.
  task automatic send_header(input logic [7:0] id_len, input logic [7:0] cmap,
                             input logic [7:0] itype, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] bits,
                             input logic [7:0] desc);
    logic [7:0] hdr [0:17];
    foreach (hdr[i]) hdr[i] = 8'($urandom_range(0, 255));
    hdr[HDR_ID_LEN]    = id_len;
    hdr[HDR_CMAP_TYPE] = cmap;
    hdr[HDR_IMG_TYPE]  = itype;
    hdr[HDR_WIDTH_LO]  = w[7:0];
    hdr[HDR_WIDTH_HI]  = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    hdr[HDR_DEPTH]     = bits;
    hdr[HDR_DESC]      = desc;
    foreach (hdr[i]) send_byte(hdr[i], i == 0);
    repeat (id_len) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Sends pixel data for npix pixels. RLE data mixes raw and run packets; long runs are
  // often cut at the image end, and a raw packet may run one pixel past it. A fill of -1
  // gives random bytes; alpha_zero clears the fourth byte of each 32-bit pixel.
  task automatic send_body(input bit rle, input int unsigned bpp, input int unsigned npix,
                           input bit alpha_zero, input int fill);
    int unsigned left, cnt;
    bit          run;
    logic [7:0]  pkt, px;
    left = npix;
    while (left != 0) begin
      cnt = 1;
      run = 1'b0;
      if (rle) begin
        run = $urandom_range(0, 1);
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        if (!run && cnt > left) cnt = left + $urandom_range(0, 1);
        pkt = 8'(cnt - 1);
        pkt[PKT_RUN_BIT] = run;
        send_byte(pkt, 1'b0);
      end
      repeat (run ? 1 : cnt) begin
        for (int b = 0; b < bpp; b++) begin
          if (b == 3 && alpha_zero) px = 8'h00;
          else if (fill >= 0) px = 8'(fill);
          else px = 8'($urandom_range(0, 255));
          send_byte(px, 1'b0);
        end
      end
      left = (cnt >= left) ? 0 : left - cnt;
    end
  endtask

  task automatic send_image(input logic [7:0] itype, input logic [7:0] bits,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] id_len, input logic [7:0] desc,
                            input bit alpha_zero, input int fill);
    send_header(id_len, 8'd0, itype, w, h, bits, desc);
    send_body(itype >= TYPE_RLE_COLOR, bits / 8, w * h, alpha_zero, fill);
  endtask

  // Bytes with first low and no file open are dropped without a word.
  task automatic test_ignored_bytes();
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_raw_images();
    send_image(TYPE_RAW_COLOR, BITS_24, 16'd1, 16'd1, 8'd1, 8'hff, 1'b0, 255);
    send_image(TYPE_RAW_GRAY, BITS_8, 16'd2, 16'd1, 8'd0, 8'h00, 1'b0, 0);
    // All alpha bytes zero, so the last word must report an empty alpha channel.
    send_image(TYPE_RAW_COLOR, BITS_32, 16'd1, 16'd1, 8'd0, 8'h20, 1'b1, -1);
  endtask

  task automatic test_rle_images();
    // A 128-pixel run into a 3-pixel image is clipped; the byte after it is ignored.
    send_header(8'd0, 8'd0, TYPE_RLE_GRAY, 16'd1, 16'd3, BITS_8, 8'h00);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h11, 1'b0);
    send_image(TYPE_RLE_COLOR, BITS_32, 16'd3, 16'd2, 8'd0, 8'h20, 1'b0, -1);
  endtask

  task automatic test_bad_headers();
    send_header(8'd0, 8'd1, TYPE_RAW_COLOR, 16'd1, 16'd1, BITS_24, 8'h00);
    send_header(8'd0, 8'd0, 8'd1, 16'd1, 16'd1, BITS_8, 8'h00);
    send_header(8'd0, 8'd0, TYPE_RLE_COLOR, 16'd1, 16'd1, 8'd16, 8'h00);
    send_header(8'd0, 8'd0, TYPE_RLE_GRAY, 16'd1, 16'd1, BITS_24, 8'h00);
  endtask

  task automatic test_empty_images();
    send_header(8'd0, 8'd0, TYPE_RAW_GRAY, 16'd0, 16'd5, BITS_8, 8'h00);
    send_header(8'd2, 8'd0, TYPE_RLE_COLOR, 16'hffff, 16'd0, BITS_32, 8'hff);
  endtask

  // New files cut into a huge image and into a half-sent header; the last one carries
  // the longest id field.
  task automatic test_restarts();
    send_header(8'd0, 8'd0, TYPE_RAW_COLOR, 16'hffff, 16'hffff, BITS_24, 8'h00);
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
    for (int i = 0; i < 7; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
    send_image(TYPE_RAW_GRAY, BITS_8, 16'd1, 16'd1, 8'd255, 8'h00, 1'b0, -1);
  endtask

  // The sink stops for a long stretch while pixels arrive back to back, so the block
  // has to fill up and push back on its input.
  task automatic test_output_stall();
    hold_output = 1'b1;
    send_burst  = 1'b1;
    send_image(TYPE_RAW_GRAY, BITS_8, 16'd40, 16'd1, 8'd0, 8'h00, 1'b0, -1);
    send_burst  = 1'b0;
  endtask

  // Mostly small well-formed files with random content; the rest are bad headers,
  // huge images cut short, and loose noise.
  task automatic test_random_files();
    int unsigned pick, w, h, idl;
    logic [7:0]  itype, bits;
    while (bytes_sent < ItemTarget) begin
      send_burst = ($urandom_range(0, 4) == 0);
      recv_burst = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       itype = TYPE_RAW_COLOR;
        1:       itype = TYPE_RAW_GRAY;
        2:       itype = TYPE_RLE_COLOR;
        default: itype = TYPE_RLE_GRAY;
      endcase
      if (itype == TYPE_RAW_GRAY || itype == TYPE_RLE_GRAY) bits = BITS_8;
      else bits = $urandom_range(0, 1) ? BITS_32 : BITS_24;
      w    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
      h    = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
      idl  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        send_image(itype, bits, 16'(w), 16'(h), 8'(idl), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 2) == 0, -1);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end else if (pick < 16) begin
        case ($urandom_range(0, 3))
          0:       bits = BITS_8;
          1:       bits = BITS_24;
          2:       bits = BITS_32;
          default: bits = 8'($urandom_range(0, 255));
        endcase
        send_header(8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)),
                    8'($urandom_range(0, 15)), 16'(w), 16'(h), bits,
                    8'($urandom_range(0, 255)));
      end else if (pick < 19) begin
        send_header(8'(idl), 8'd0, itype, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(1, 65535)), bits, 8'($urandom_range(0, 255)));
        send_body(itype >= TYPE_RLE_COLOR, bits / 8, $urandom_range(1, 6),
                  $urandom_range(0, 1), -1);
      end else begin
        repeat ($urandom_range(3, 10)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
      end
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;
  endtask

  // Output sink: before each word it waits a random number of cycles with tready low (none in
  // a burst), or a long stretch when a hold-off has been asked for.
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        gap = HoldCycles;
        hold_output = 1'b0;
      end else begin
        gap = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compares one accepted result word with the oldest expected one, field by field.
  task automatic check_word();
    result_t seen, want;
    string   diffs;
    seen.kind          = kind_e'(m_axis_tuser);
    seen.red           = m_axis_tdata[7:0];
    seen.green         = m_axis_tdata[15:8];
    seen.blue          = m_axis_tdata[23:16];
    seen.alpha         = m_axis_tdata[31:24];
    seen.start_index   = m_axis_tdata[63:32];
    seen.run_length    = m_axis_tdata[71:64];
    seen.image_width   = m_axis_tdata[87:72];
    seen.image_height  = m_axis_tdata[103:88];
    seen.flip_vertical = m_axis_tdata[104];
    seen.alpha_empty   = m_axis_tdata[105];
    seen.last          = m_axis_tlast;
    diffs = "";
    if (pending_results.size() == 0) begin
      if (n_errors < 10) begin
        $display("word %0d not expected: tuser %h tdata %h tlast %b",
                 n_words, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end
      n_errors++;
    end else begin
      want = pending_results.pop_front();
      if (seen.kind !== want.kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", want.kind, seen.kind)};
      if (seen.red !== want.red)
        diffs = {diffs, $sformatf(" red %h/%h", want.red, seen.red)};
      if (seen.green !== want.green)
        diffs = {diffs, $sformatf(" green %h/%h", want.green, seen.green)};
      if (seen.blue !== want.blue)
        diffs = {diffs, $sformatf(" blue %h/%h", want.blue, seen.blue)};
      if (seen.alpha !== want.alpha)
        diffs = {diffs, $sformatf(" alpha %h/%h", want.alpha, seen.alpha)};
      if (seen.start_index !== want.start_index)
        diffs = {diffs, $sformatf(" start %0d/%0d", want.start_index, seen.start_index)};
      if (seen.run_length !== want.run_length)
        diffs = {diffs, $sformatf(" run %0d/%0d", want.run_length, seen.run_length)};
      if (seen.image_width !== want.image_width)
        diffs = {diffs, $sformatf(" width %0d/%0d", want.image_width, seen.image_width)};
      if (seen.image_height !== want.image_height)
        diffs = {diffs, $sformatf(" height %0d/%0d", want.image_height, seen.image_height)};
      if (seen.flip_vertical !== want.flip_vertical)
        diffs = {diffs, $sformatf(" flip %b/%b", want.flip_vertical, seen.flip_vertical)};
      if (seen.last !== want.last)
        diffs = {diffs, $sformatf(" last %b/%b", want.last, seen.last)};
      if (seen.alpha_empty !== want.alpha_empty)
        diffs = {diffs, $sformatf(" alpha_empty %b/%b", want.alpha_empty, seen.alpha_empty)};
      if (m_axis_tdata[TdataW-1:106] !== '0)
        diffs = {diffs, $sformatf(" pad %h/0", m_axis_tdata[TdataW-1:106])};
      if (diffs != "") begin
        if (n_errors < 10) $display("word %0d differs (expected/actual):%s", n_words, diffs);
        n_errors++;
      end
    end
    n_words++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_word();
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_tga_rle_decoder: errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_bytes();
    test_raw_images();
    test_rle_images();
    test_bad_headers();
    test_empty_images();
    test_restarts();
    test_output_stall();
    test_random_files();
    s_axis_tvalid <= 1'b0;
    // Let every expected word come out, then give stray words time to show up.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_tga_rle_decoder: clean");
    end else begin
      $display("tb_tga_rle_decoder: errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tga_pkg.sv
rtl/tga_in_stage.sv
rtl/tga_core.sv
rtl/tga_out_stage.sv
rtl/tga_rle_decoder.sv
dv/tb_tga_rle_decoder.sv
